// ----- rtl/b2rd_pkg.sv -----
// ----------------------------------------------------------------------------
// b2rd_pkg - shared types and constants of the radix digit converter
// Register codes, field widths, the job and result control records, and the
// reciprocal table used by the digit divider.
// ----------------------------------------------------------------------------
`default_nettype none

package b2rd_pkg;

	localparam int VALUE_W     = 32;
	localparam int BASE_W      = 5;
	localparam int COUNT_W     = 4;
	localparam int DIGIT_W     = 4;
	localparam int SHIFT_W     = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam int MAX_DIGITS_DEF = 10;
	// position and digit_count are four bits wide, so no more than this
	localparam int COUNT_LIMIT    = 15;

	localparam logic [CFG_IDX_W-1:0] REG_NUMERIC_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT  = 2'd1;

	localparam logic [BASE_W-1:0]  BASE_RESET  = 5'd10;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd10;
	localparam logic [BASE_W-1:0]  BASE_MIN    = 5'd2;
	localparam logic [BASE_W-1:0]  BASE_MAX    = 5'd16;

	// One queued conversion: value plus everything the divider needs.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] mlo;
		logic [SHIFT_W-1:0] shift;
		logic [BASE_W-1:0]  base;
		logic [COUNT_W-1:0] count;
	} job_t;

	// Handshake from divider to emitter.
	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] count;
		logic               ovf;
	} res_ctl_t;

	typedef struct packed {
		logic [VALUE_W-1:0] mlo;
		logic [SHIFT_W-1:0] shift;
	} recip_t;

	// Quotient n / b = (n * (2^32 + mlo)) >> (32 + shift), exact for any
	// 32-bit n. mlo is the low word of floor(2^(32+l)/b) + 1, l = ceil(log2 b).
	function automatic recip_t recip(input logic [BASE_W-1:0] b);
		recip_t r;
		unique case (b)
			5'd2:    r = '{mlo: 32'h0000_0001, shift: 3'd1};
			5'd3:    r = '{mlo: 32'h5555_5556, shift: 3'd2};
			5'd4:    r = '{mlo: 32'h0000_0001, shift: 3'd2};
			5'd5:    r = '{mlo: 32'h9999_999A, shift: 3'd3};
			5'd6:    r = '{mlo: 32'h5555_5556, shift: 3'd3};
			5'd7:    r = '{mlo: 32'h2492_4925, shift: 3'd3};
			5'd8:    r = '{mlo: 32'h0000_0001, shift: 3'd3};
			5'd9:    r = '{mlo: 32'hC71C_71C8, shift: 3'd4};
			5'd10:   r = '{mlo: 32'h9999_999A, shift: 3'd4};
			5'd11:   r = '{mlo: 32'h745D_1746, shift: 3'd4};
			5'd12:   r = '{mlo: 32'h5555_5556, shift: 3'd4};
			5'd13:   r = '{mlo: 32'h3B13_B13C, shift: 3'd4};
			5'd14:   r = '{mlo: 32'h2492_4925, shift: 3'd4};
			5'd15:   r = '{mlo: 32'h1111_1112, shift: 3'd4};
			5'd16:   r = '{mlo: 32'h0000_0001, shift: 3'd4};
			default: r = '{mlo: 32'h0000_0001, shift: 3'd4};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/binary_to_radix_digits_unit.sv -----
// ----------------------------------------------------------------------------
// binary_to_radix_digits_unit - binary value to radix digits converter
// Splits each 32-bit value into digit_count digits of base numeric_base,
// least significant first, with the top digit marked last and an overflow
// flag when the value does not fit.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  --------  ---------  --------------------  ---------------------------------
//  input     in         in_valid / in_stall   value
//  output    out        out_valid / out_stall digit, position, last, overflow
//  config    in         cfg_wr_en             cfg_index, cfg_data
//
//  Per value of N digits the divider loads a job, then for each digit does
//  a reciprocal multiply followed by a quotient/remainder fix-up. The
//  emitter shows N results, one a cycle unless stalled, overlapping the
//  next division.
//  Reset clears the queue, both sequencers and the registers (base 10,
//  ten digits). A stalled output holds; the queue keeps taking input until
//  it is full, and in_stall is simply queue full.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_radix_digits_unit #(
	parameter int MAX_DIGITS = b2rd_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [b2rd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [b2rd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [b2rd_pkg::VALUE_W-1:0]    value,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [b2rd_pkg::DIGIT_W-1:0]         digit,
	output logic [b2rd_pkg::COUNT_W-1:0]         position,
	output logic                                 last,
	output logic                                 overflow
);

	// digit buffers never need more than the 4-bit position can address
	localparam int DEPTH = (MAX_DIGITS < b2rd_pkg::COUNT_LIMIT) ?
		MAX_DIGITS : b2rd_pkg::COUNT_LIMIT;
	localparam int JOB_W = $bits(b2rd_pkg::job_t);

	logic                                    q_full;
	logic                                    q_empty;
	logic                                    q_push;
	logic                                    q_pop;
	b2rd_pkg::job_t                          push_job;
	b2rd_pkg::job_t                          pop_job;
	logic [JOB_W-1:0]                        pop_bits;
	b2rd_pkg::res_ctl_t                      res_ctl;
	logic [DEPTH-1:0][b2rd_pkg::DIGIT_W-1:0] res_digits;
	logic                                    res_take;

	assign in_stall = q_full;
	assign pop_job  = b2rd_pkg::job_t'(pop_bits);

	// front: registers, clamping, reciprocal lookup
	b2rd_front #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.value     (value),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	// decouple acceptance from the multi-cycle division
	b2rd_queue #(
		.WIDTH (JOB_W),
		.DEPTH (b2rd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_bits),
		.empty     (q_empty)
	);

	// back: digit extraction
	b2rd_divider #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (pop_job),
		.q_pop      (q_pop),
		.res_ctl    (res_ctl),
		.res_digits (res_digits),
		.res_take   (res_take)
	);

	// back: result delivery, one transaction per digit
	b2rd_emitter #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_ctl    (res_ctl),
		.res_digits (res_digits),
		.res_take   (res_take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit      (digit),
		.position   (position),
		.last       (last),
		.overflow   (overflow)
	);

endmodule

`default_nettype wire

// ----- rtl/b2rd_queue.sv -----
// ----------------------------------------------------------------------------
// b2rd_queue - small job queue between front and back
// Circular buffer; full and empty come straight from the fill counter.
// ----------------------------------------------------------------------------
`default_nettype none

module b2rd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = b2rd_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= nxt(wr_ptr_q);
			if (pop)  rd_ptr_q <= nxt(rd_ptr_q);
			if (push && !pop)      fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ----- rtl/b2rd_front.sv -----
// ----------------------------------------------------------------------------
// b2rd_front - configuration registers and input classification
// Holds the two registers, clamps base and count into range, looks up the
// reciprocal for the base and forms a job for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b2rd_front #(
	parameter int MAX_DIGITS = b2rd_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [b2rd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [b2rd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	input  wire logic [b2rd_pkg::VALUE_W-1:0]    value,
	input  wire logic                            q_full,
	output logic                                 q_push,
	output b2rd_pkg::job_t                       q_job
);

	localparam int DEPTH = (MAX_DIGITS < b2rd_pkg::COUNT_LIMIT) ?
		MAX_DIGITS : b2rd_pkg::COUNT_LIMIT;
	localparam logic [b2rd_pkg::COUNT_W-1:0] CNT_MAX = b2rd_pkg::COUNT_W'(DEPTH);

	logic [b2rd_pkg::BASE_W-1:0]  numeric_base_q;
	logic [b2rd_pkg::COUNT_W-1:0] digit_count_q;
	logic [b2rd_pkg::BASE_W-1:0]  eff_base;
	logic [b2rd_pkg::COUNT_W-1:0] eff_count;
	b2rd_pkg::recip_t             rc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numeric_base_q <= b2rd_pkg::BASE_RESET;
			digit_count_q  <= b2rd_pkg::COUNT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				b2rd_pkg::REG_NUMERIC_BASE: numeric_base_q <= cfg_data;
				b2rd_pkg::REG_DIGIT_COUNT:  digit_count_q  <= cfg_data[b2rd_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (numeric_base_q < b2rd_pkg::BASE_MIN)      eff_base = b2rd_pkg::BASE_MIN;
		else if (numeric_base_q > b2rd_pkg::BASE_MAX) eff_base = b2rd_pkg::BASE_MAX;
		else                                          eff_base = numeric_base_q;

		if (digit_count_q == '0)        eff_count = b2rd_pkg::COUNT_W'(1);
		else if (digit_count_q > CNT_MAX) eff_count = CNT_MAX;
		else                            eff_count = digit_count_q;

		rc = b2rd_pkg::recip(eff_base);
	end

	assign q_push      = in_valid && !q_full;
	assign q_job.value = value;
	assign q_job.mlo   = rc.mlo;
	assign q_job.shift = rc.shift;
	assign q_job.base  = eff_base;
	assign q_job.count = eff_count;

endmodule

`default_nettype wire

// ----- rtl/b2rd_divider.sv -----
// ----------------------------------------------------------------------------
// b2rd_divider - iterative digit extraction
// Per digit: multiply by the base reciprocal, then form quotient
// and remainder. Holds the finished digit set until the emitter takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module b2rd_divider #(
	parameter int MAX_DIGITS = b2rd_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    q_empty,
	input  wire b2rd_pkg::job_t          q_job,
	output logic                         q_pop,
	output b2rd_pkg::res_ctl_t           res_ctl,
	output logic [((MAX_DIGITS < b2rd_pkg::COUNT_LIMIT) ? MAX_DIGITS :
		b2rd_pkg::COUNT_LIMIT)-1:0][b2rd_pkg::DIGIT_W-1:0] res_digits,
	input  wire logic                    res_take
);

	localparam int DEPTH = (MAX_DIGITS < b2rd_pkg::COUNT_LIMIT) ?
		MAX_DIGITS : b2rd_pkg::COUNT_LIMIT;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = b2rd_pkg::VALUE_W;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_FIX, ST_DONE} state_t;

	state_t                           state_q;
	logic [VW-1:0]                    rest_q;
	logic [VW-1:0]                    mlo_q;
	logic [b2rd_pkg::SHIFT_W-1:0]     shift_q;
	logic [b2rd_pkg::BASE_W-1:0]      base_q;
	logic [b2rd_pkg::COUNT_W-1:0]     count_q;
	logic [b2rd_pkg::COUNT_W-1:0]     k_q;
	logic                             ovf_q;
	logic [2*VW-1:0]                  prod_s1;
	logic [DEPTH-1:0][b2rd_pkg::DIGIT_W-1:0] digits_q;

	logic [VW:0]                      hi;
	logic [VW:0]                      quo;
	logic [8:0]                       qb;
	logic [b2rd_pkg::DIGIT_W-1:0]     rdig;
	logic                             start;

	// n + high word of n*mlo, then the base-dependent shift gives floor(n/b);
	// the remainder only needs the low nibble of q*b
	always_comb begin
		hi   = {1'b0, rest_q} + {1'b0, prod_s1[2*VW-1:VW]};
		quo  = hi >> shift_q;
		qb   = {5'b0, quo[3:0]} * {4'b0, base_q};
		rdig = rest_q[3:0] - qb[3:0];
	end

	assign start = !q_empty && ((state_q == ST_IDLE) || (state_q == ST_DONE && res_take));
	assign q_pop = start;

	assign res_ctl.valid = (state_q == ST_DONE);
	assign res_ctl.count = count_q;
	assign res_ctl.ovf   = ovf_q;
	assign res_digits    = digits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rest_q   <= '0;
			mlo_q    <= '0;
			shift_q  <= '0;
			base_q   <= '0;
			count_q  <= '0;
			k_q      <= '0;
			ovf_q    <= 1'b0;
			prod_s1  <= '0;
			digits_q <= '0;
		end else begin
			unique case (state_q) inside
				ST_IDLE, ST_DONE: begin
					if (start) begin
						rest_q  <= q_job.value;
						mlo_q   <= q_job.mlo;
						shift_q <= q_job.shift;
						base_q  <= q_job.base;
						count_q <= q_job.count;
						k_q     <= '0;
						state_q <= ST_MUL;
					end else if (state_q == ST_DONE && res_take) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					prod_s1 <= {{VW{1'b0}}, rest_q} * {{VW{1'b0}}, mlo_q};
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					digits_q[k_q[IDX_W-1:0]] <= rdig;
					rest_q <= quo[VW-1:0];
					if (k_q == count_q - 1'b1) begin
						ovf_q   <= (quo != '0);
						state_q <= ST_DONE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/b2rd_emitter.sv -----
// ----------------------------------------------------------------------------
// b2rd_emitter - result output register
// Loads a finished digit set and shows one digit a cycle unless stalled, least
// significant first; the divider is free to work on the next value meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module b2rd_emitter #(
	parameter int MAX_DIGITS = b2rd_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire b2rd_pkg::res_ctl_t      res_ctl,
	input  wire logic [((MAX_DIGITS < b2rd_pkg::COUNT_LIMIT) ? MAX_DIGITS :
		b2rd_pkg::COUNT_LIMIT)-1:0][b2rd_pkg::DIGIT_W-1:0] res_digits,
	output logic                         res_take,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [b2rd_pkg::DIGIT_W-1:0] digit,
	output logic [b2rd_pkg::COUNT_W-1:0] position,
	output logic                         last,
	output logic                         overflow
);

	localparam int DEPTH = (MAX_DIGITS < b2rd_pkg::COUNT_LIMIT) ?
		MAX_DIGITS : b2rd_pkg::COUNT_LIMIT;

	logic                                    valid_q;
	logic [b2rd_pkg::COUNT_W-1:0]            pos_q;
	logic [b2rd_pkg::COUNT_W-1:0]            rem_q;
	logic                                    ovf_q;
	logic [DEPTH-1:0][b2rd_pkg::DIGIT_W-1:0] buf_q;
	logic                                    advance;

	assign advance  = valid_q && !out_stall;
	assign res_take = res_ctl.valid && (!valid_q || (advance && rem_q == '0));

	assign out_valid = valid_q;
	assign digit     = buf_q[0];
	assign position  = pos_q;
	assign last      = (rem_q == '0);
	assign overflow  = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
			rem_q   <= '0;
		end else if (res_take) begin
			valid_q <= 1'b1;
			pos_q   <= '0;
			rem_q   <= res_ctl.count - 1'b1;
		end else if (advance) begin
			if (rem_q == '0) begin
				valid_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			buf_q <= res_digits;
			ovf_q <= res_ctl.ovf;
		end else if (advance) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/b2rd_checker.sv -----
// ----------------------------------------------------------------------------
// b2rd_checker - port-level checks of the converter
// Watches the output channel: stall hold, digit ordering within a value and
// the start of each new value.
// ----------------------------------------------------------------------------
`default_nettype none

module b2rd_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic [b2rd_pkg::DIGIT_W-1:0]    digit,
	input wire logic [b2rd_pkg::COUNT_W-1:0]    position,
	input wire logic                            last,
	input wire logic                            overflow
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digit) && $stable(position)
			&& $stable(last) && $stable(overflow))
		else $error("stalled result changed");

	// advance to the next digit of the same value
	a_next_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid
			&& position == $past(position) + 1'b1 && overflow == $past(overflow))
		else $error("digit sequence broken within a value");

	// a new value starts at position zero
	a_new_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid || position == '0)
		else $error("value did not start at least significant digit");

	// after an empty output cycle the next result is a first digit
	a_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> !out_valid || position == '0)
		else $error("result appeared mid-value");

endmodule

bind binary_to_radix_digits_unit b2rd_checker u_b2rd_checker (.*);

`default_nettype wire
